// File: hw/rtl/masked_sparse_triple_product_update_macros.svh
`ifndef MASKED_SPARSE_TRIPLE_PRODUCT_UPDATE_MACROS_SVH
`define MASKED_SPARSE_TRIPLE_PRODUCT_UPDATE_MACROS_SVH

// same-cycle implication
`define MSPTU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("msptu assertion failed");

// next-cycle implication
`define MSPTU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("msptu assertion failed");

`endif

// File: hw/rtl/msptu_pkg.sv
`default_nettype none
package msptu_pkg;

    localparam int DOF_COUNT = 4096;
    localparam int DOF_AW    = $clog2(DOF_COUNT);

    localparam logic [1:0] KIND_SCALE = 2'd0;
    localparam logic [1:0] KIND_ACC   = 2'd1;
    localparam logic [1:0] KIND_APPLY = 2'd2;

    localparam logic [1:0] MODE_OFFDIAG = 2'd0;

    localparam logic [1:0] FOP_ADD = 2'd0;
    localparam logic [1:0] FOP_SUB = 2'd1;
    localparam logic [1:0] FOP_MUL = 2'd2;
    localparam logic [1:0] FOP_DIV = 2'd3;

    localparam logic [63:0] DBL_HALF      = 64'h3FE0_0000_0000_0000;
    localparam logic [63:0] DBL_NAN_DEF   = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] DBL_NAN_POS   = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] DBL_QUIET_BIT = 64'h0008_0000_0000_0000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] column;
        logic [63:0] tilde_g_entry;
        logic [63:0] mass_entry;
        logic [63:0] g_entry;
        logic [63:0] first_entry;
        logic [63:0] second_entry;
        logic [63:0] third_entry;
    } t_cmd;

    typedef struct packed {
        logic [11:0] column_out;
        logic [63:0] new_first;
        logic [63:0] new_second;
        logic [63:0] new_third;
    } t_res;

    typedef struct packed {
        logic        go;
        logic [1:0]  op;
        logic [63:0] a;
        logic [63:0] b;
    } t_fpu_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] result;
    } t_fpu_rsp;

endpackage
`default_nettype wire

// File: hw/rtl/msptu_fpu.sv
`default_nettype none
module msptu_fpu (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  msptu_pkg::t_fpu_req i_req,
    output msptu_pkg::t_fpu_rsp o_rsp
);
    import msptu_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PRE   = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_MULX  = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_ALIGN = 4'd5;
    localparam logic [3:0] S_NORM  = 4'd6;
    localparam logic [3:0] S_ROUND = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]         r_state, n_state;
    logic [1:0]         r_op, n_op;
    logic               r_sign, n_sign;
    logic               r_sb, n_sb;
    logic signed [13:0] r_ea, n_ea, r_eb, n_eb, r_exp, n_exp;
    logic [52:0]        r_ma, n_ma, r_mb, n_mb;
    logic [64:0]        r_x, n_x;
    logic [105:0]       r_acc, n_acc;
    logic [53:0]        r_rem, n_rem;
    logic [63:0]        r_q, n_q;
    logic [5:0]         r_cnt, n_cnt;
    logic [63:0]        r_res, n_res;

    // operand decode and special cases
    logic        sa, sb, sbe;
    logic [10:0] eaf, ebf;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic        sp_hit;
    logic [63:0] sp_val;

    always_comb begin
        sa     = i_req.a[63];
        sb     = i_req.b[63];
        sbe    = (i_req.op == FOP_SUB) ? ~sb : sb;
        eaf    = i_req.a[62:52];
        ebf    = i_req.b[62:52];
        a_nan  = (eaf == 11'h7FF) && (i_req.a[51:0] != 52'd0);
        b_nan  = (ebf == 11'h7FF) && (i_req.b[51:0] != 52'd0);
        a_inf  = (eaf == 11'h7FF) && (i_req.a[51:0] == 52'd0);
        b_inf  = (ebf == 11'h7FF) && (i_req.b[51:0] == 52'd0);
        a_zero = (i_req.a[62:0] == 63'd0);
        b_zero = (i_req.b[62:0] == 63'd0);
        sp_hit = 1'b1;
        sp_val = '0;
        if (i_req.op == FOP_DIV && b_zero) begin
            if (a_zero || a_nan) begin
                sp_val = DBL_NAN_POS;
            end else begin
                sp_val = {sa ^ sb, 11'h7FF, 52'd0};
            end
        end else if (a_nan) begin
            sp_val = i_req.a | DBL_QUIET_BIT;
        end else if (b_nan) begin
            sp_val = i_req.b | DBL_QUIET_BIT;
        end else begin
            case (i_req.op)
                FOP_ADD, FOP_SUB: begin
                    if (a_inf && b_inf && (sa != sbe)) begin
                        sp_val = DBL_NAN_DEF;
                    end else if (a_inf) begin
                        sp_val = i_req.a;
                    end else if (b_inf) begin
                        sp_val = {sbe, 11'h7FF, 52'd0};
                    end else begin
                        sp_hit = 1'b0;
                    end
                end
                FOP_MUL: begin
                    if ((a_inf && b_zero) || (a_zero && b_inf)) begin
                        sp_val = DBL_NAN_DEF;
                    end else if (a_inf || b_inf) begin
                        sp_val = {sa ^ sb, 11'h7FF, 52'd0};
                    end else if (a_zero || b_zero) begin
                        sp_val = {sa ^ sb, 63'd0};
                    end else begin
                        sp_hit = 1'b0;
                    end
                end
                default: begin
                    if (a_inf && b_inf) begin
                        sp_val = DBL_NAN_DEF;
                    end else if (a_inf) begin
                        sp_val = {sa ^ sb, 11'h7FF, 52'd0};
                    end else if (b_inf || a_zero) begin
                        sp_val = {sa ^ sb, 63'd0};
                    end else begin
                        sp_hit = 1'b0;
                    end
                end
            endcase
        end
    end

    // multiply partial product
    logic [26:0]  ah, bh;
    logic [53:0]  pp;
    logic [1:0]   ppos;
    logic [105:0] ppw;

    always_comb begin
        ah   = r_cnt[1] ? {1'b0, r_ma[52:27]} : r_ma[26:0];
        bh   = r_cnt[0] ? {1'b0, r_mb[52:27]} : r_mb[26:0];
        pp   = ah * bh;
        ppos = {1'b0, r_cnt[1]} + {1'b0, r_cnt[0]};
        case (ppos)
            2'd0:    ppw = {52'd0, pp};
            2'd1:    ppw = {25'd0, pp, 27'd0};
            default: ppw = {pp[51:0], 54'd0};
        endcase
    end

    // divide step
    logic        ge;
    logic [53:0] diff;

    always_comb begin
        ge   = r_rem >= {1'b0, r_mb};
        diff = ge ? (r_rem - {1'b0, r_mb}) : r_rem;
    end

    // add alignment
    logic               a_big;
    logic signed [13:0] ebig, esml, dsh;
    logic [52:0]        mbig, msml;
    logic               sbig;
    logic [63:0]        xs, xsh, xal;
    logic               lost;
    logic [64:0]        sum;

    always_comb begin
        a_big = {r_ea, r_ma} >= {r_eb, r_mb};
        ebig  = a_big ? r_ea : r_eb;
        esml  = a_big ? r_eb : r_ea;
        mbig  = a_big ? r_ma : r_mb;
        msml  = a_big ? r_mb : r_ma;
        sbig  = a_big ? r_sign : r_sb;
        dsh   = ebig - esml;
        xs    = {msml, 11'd0};
        if (dsh >= 14'sd64) begin
            xsh  = '0;
            lost = |xs;
        end else begin
            xsh  = xs >> dsh[5:0];
            lost = (xsh << dsh[5:0]) != xs;
        end
        xal = {xsh[63:1], xsh[0] | lost};
        if (r_sign ^ r_sb) begin
            sum = {1'b0, mbig, 11'd0} - {1'b0, xal};
        end else begin
            sum = {1'b0, mbig, 11'd0} + {1'b0, xal};
        end
    end

    // rounding
    logic               rinc;
    logic [53:0]        m2;
    logic signed [13:0] fexp;
    logic [63:0]        rres;

    always_comb begin
        rinc = r_x[10] & ((|r_x[9:0]) | r_x[11]);
        m2   = {1'b0, r_x[63:11]} + {53'd0, rinc};
        if (m2[53]) begin
            fexp = r_exp + 14'sd1;
        end else if (m2[52]) begin
            fexp = r_exp;
        end else begin
            fexp = 14'sd0;
        end
        if (fexp >= 14'sd2047) begin
            rres = {r_sign, 11'h7FF, 52'd0};
        end else begin
            rres = {r_sign, fexp[10:0], m2[53] ? 52'd0 : m2[51:0]};
        end
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_sign  = r_sign;
        n_sb    = r_sb;
        n_ea    = r_ea;
        n_eb    = r_eb;
        n_ma    = r_ma;
        n_mb    = r_mb;
        n_exp   = r_exp;
        n_x     = r_x;
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_q     = r_q;
        n_cnt   = r_cnt;
        n_res   = r_res;
        case (r_state)
            S_IDLE: begin
                if (i_req.go) begin
                    n_op = i_req.op;
                    n_ea = (eaf == 11'd0) ? 14'sd1 : $signed({3'd0, eaf});
                    n_eb = (ebf == 11'd0) ? 14'sd1 : $signed({3'd0, ebf});
                    n_ma = {eaf != 11'd0, i_req.a[51:0]};
                    n_mb = {ebf != 11'd0, i_req.b[51:0]};
                    if (sp_hit) begin
                        n_res   = sp_val;
                        n_state = S_DONE;
                    end else if (i_req.op == FOP_ADD || i_req.op == FOP_SUB) begin
                        n_sign  = sa;
                        n_sb    = sbe;
                        n_state = S_ALIGN;
                    end else begin
                        n_sign  = sa ^ sb;
                        n_state = S_PRE;
                    end
                end
            end
            S_PRE: begin
                if (!r_ma[52]) begin
                    n_ma = {r_ma[51:0], 1'b0};
                    n_ea = r_ea - 14'sd1;
                end
                if (!r_mb[52]) begin
                    n_mb = {r_mb[51:0], 1'b0};
                    n_eb = r_eb - 14'sd1;
                end
                if (r_ma[52] && r_mb[52]) begin
                    n_cnt   = '0;
                    n_acc   = '0;
                    n_rem   = {1'b0, r_ma};
                    n_q     = '0;
                    n_state = (r_op == FOP_MUL) ? S_MUL : S_DIV;
                end
            end
            S_MUL: begin
                n_acc = r_acc + ppw;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt[1:0] == 2'd3) begin
                    n_state = S_MULX;
                end
            end
            S_MULX: begin
                n_x     = {1'b0, r_acc[105:43], r_acc[42] | (|r_acc[41:0])};
                n_exp   = r_ea + r_eb - 14'sd1022;
                n_state = S_NORM;
            end
            S_DIV: begin
                n_rem = {diff[52:0], 1'b0};
                n_q   = {r_q[62:0], ge};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_x     = {1'b0, r_q[62:0], ge | (diff != 54'd0)};
                    n_exp   = r_ea - r_eb + 14'sd1023;
                    n_state = S_NORM;
                end
            end
            S_ALIGN: begin
                n_x     = sum;
                n_exp   = ebig;
                n_sign  = (sum == 65'd0) ? (r_sign & r_sb) : sbig;
                n_state = S_NORM;
            end
            S_NORM: begin
                if (r_x[64]) begin
                    n_x   = {1'b0, r_x[64:2], r_x[1] | r_x[0]};
                    n_exp = r_exp + 14'sd1;
                end else if (r_x == 65'd0) begin
                    n_state = S_ROUND;
                end else if (r_exp < -14'sd70) begin
                    n_x   = {64'd0, 1'b1};
                    n_exp = 14'sd1;
                end else if (r_exp < 14'sd1) begin
                    n_x   = {1'b0, r_x[64:2], r_x[1] | r_x[0]};
                    n_exp = r_exp + 14'sd1;
                end else if (!r_x[63] && r_exp > 14'sd1) begin
                    n_x   = {r_x[63:0], 1'b0};
                    n_exp = r_exp - 14'sd1;
                end else begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                n_res   = rres;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_op   <= n_op;
        r_sign <= n_sign;
        r_sb   <= n_sb;
        r_ea   <= n_ea;
        r_eb   <= n_eb;
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_exp  <= n_exp;
        r_x    <= n_x;
        r_acc  <= n_acc;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_cnt  <= n_cnt;
        r_res  <= n_res;
    end

    assign o_rsp.busy   = (r_state != S_IDLE);
    assign o_rsp.done   = (r_state == S_DONE);
    assign o_rsp.result = r_res;

endmodule
`default_nettype wire

// File: hw/rtl/masked_sparse_triple_product_update.sv
`default_nettype none
// Sparse accumulator row update in IEEE double. An item is taken when start
// is high and busy is low; one item is worked at a time on a shared
// iterative double unit (add, multiply in four 27x27 partial products,
// radix-2 divide), so cycles per item depend on the operation and operands:
// a scale item takes 64 divide steps unless an operand is zero, infinite or
// NaN, and normalizing subnormal values makes an item longer. After reset the
// accumulator memory is cleared one word a cycle, with busy high. A result is
// shown on o_res for one cycle with o_res_valid; the receiver cannot stall it.
// block_mode is written whenever i_cfg_we is high.
`include "masked_sparse_triple_product_update_macros.svh"
module masked_sparse_triple_product_update (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  msptu_pkg::t_cmd i_cmd,
    output logic            o_res_valid,
    output msptu_pkg::t_res o_res,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_data
);
    import msptu_pkg::*;

    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_RD      = 4'd2;
    localparam logic [3:0] S_DIV_GO  = 4'd3;
    localparam logic [3:0] S_DIV_W   = 4'd4;
    localparam logic [3:0] S_AMUL_GO = 4'd5;
    localparam logic [3:0] S_AMUL_W  = 4'd6;
    localparam logic [3:0] S_AADD_GO = 4'd7;
    localparam logic [3:0] S_AADD_W  = 4'd8;
    localparam logic [3:0] S_HALF_GO = 4'd9;
    localparam logic [3:0] S_HALF_W  = 4'd10;
    localparam logic [3:0] S_SUB_GO  = 4'd11;
    localparam logic [3:0] S_SUB_W   = 4'd12;
    localparam logic [3:0] S_EMIT    = 4'd13;

    logic [3:0]        r_state, n_state;
    t_cmd              r_cmd;
    logic [1:0]        r_mode;
    logic [63:0]       r_scale;
    logic [DOF_AW-1:0] r_clr;
    logic [63:0]       r_rdata;
    logic [63:0]       r_prod;
    logic [63:0]       r_half;
    logic [1:0]        r_lane;
    logic [63:0]       r_new1, r_new2, r_new3;

    logic [63:0]       r_mem [DOF_COUNT];

    t_fpu_req          fpu_req;
    t_fpu_rsp          fpu_rsp;

    logic              col_ok;
    logic [63:0]       v;
    logic [63:0]       lane_a;
    logic              w_en;
    logic [DOF_AW-1:0] w_addr;
    logic [63:0]       w_data;

    msptu_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fpu_req),
        .o_rsp   (fpu_rsp)
    );

    assign col_ok = ({1'b0, r_cmd.column} < 13'(DOF_COUNT));
    assign v      = col_ok ? r_rdata : 64'd0;

    always_comb begin
        case (r_lane)
            2'd0:    lane_a = r_cmd.first_entry;
            2'd1:    lane_a = r_cmd.second_entry;
            default: lane_a = r_cmd.third_entry;
        endcase
    end

    always_comb begin
        fpu_req = '0;
        case (r_state)
            S_DIV_GO: begin
                fpu_req = '{go: 1'b1, op: FOP_DIV, a: r_cmd.tilde_g_entry, b: r_cmd.mass_entry};
            end
            S_AMUL_GO: begin
                fpu_req = '{go: 1'b1, op: FOP_MUL, a: r_scale, b: r_cmd.g_entry};
            end
            S_AADD_GO: begin
                fpu_req = '{go: 1'b1, op: FOP_ADD, a: v, b: r_prod};
            end
            S_HALF_GO: begin
                fpu_req = '{go: 1'b1, op: FOP_MUL, a: v, b: DBL_HALF};
            end
            S_SUB_GO: begin
                fpu_req = '{go: 1'b1, op: FOP_SUB, a: lane_a,
                            b: (r_mode == r_lane + 2'd1) ? v : r_half};
            end
            default: begin
                fpu_req = '0;
            end
        endcase
    end

    always_comb begin
        w_en   = 1'b0;
        w_addr = r_cmd.column[DOF_AW-1:0];
        w_data = 64'd0;
        case (r_state)
            S_CLR: begin
                w_en   = 1'b1;
                w_addr = r_clr;
            end
            S_AADD_W: begin
                w_en   = fpu_rsp.done && col_ok;
                w_data = fpu_rsp.result;
            end
            S_EMIT: begin
                w_en = col_ok;
            end
            default: begin
                w_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        if (r_state == S_RD) begin
            r_rdata <= r_mem[r_cmd.column[DOF_AW-1:0]];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (r_clr == DOF_AW'(DOF_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                case (r_cmd.kind)
                    KIND_SCALE: n_state = S_DIV_GO;
                    KIND_ACC:   n_state = col_ok ? S_AMUL_GO : S_IDLE;
                    KIND_APPLY: n_state = S_HALF_GO;
                    default:    n_state = S_IDLE;
                endcase
            end
            S_DIV_GO:  n_state = S_DIV_W;
            S_DIV_W:   n_state = fpu_rsp.done ? S_IDLE : S_DIV_W;
            S_AMUL_GO: n_state = S_AMUL_W;
            S_AMUL_W:  n_state = fpu_rsp.done ? S_AADD_GO : S_AMUL_W;
            S_AADD_GO: n_state = S_AADD_W;
            S_AADD_W:  n_state = fpu_rsp.done ? S_IDLE : S_AADD_W;
            S_HALF_GO: n_state = S_HALF_W;
            S_HALF_W:  n_state = fpu_rsp.done ? S_SUB_GO : S_HALF_W;
            S_SUB_GO:  n_state = S_SUB_W;
            S_SUB_W: begin
                if (fpu_rsp.done) begin
                    if (r_mode == MODE_OFFDIAG || r_lane == 2'd2) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_SUB_GO;
                    end
                end
            end
            S_EMIT:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_mode  <= MODE_OFFDIAG;
            r_scale <= 64'd0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + DOF_AW'(1);
            end
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            if (r_state == S_DIV_W && fpu_rsp.done) begin
                r_scale <= fpu_rsp.result;
            end
        end
        if (r_state == S_IDLE && start) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_AMUL_W && fpu_rsp.done) begin
            r_prod <= fpu_rsp.result;
        end
        if (r_state == S_HALF_GO) begin
            r_lane <= 2'd0;
            r_new2 <= 64'd0;
            r_new3 <= 64'd0;
        end
        if (r_state == S_HALF_W && fpu_rsp.done) begin
            r_half <= fpu_rsp.result;
        end
        if (r_state == S_SUB_W && fpu_rsp.done) begin
            r_lane <= r_lane + 2'd1;
            case (r_lane)
                2'd0:    r_new1 <= fpu_rsp.result;
                2'd1:    r_new2 <= fpu_rsp.result;
                default: r_new3 <= fpu_rsp.result;
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_EMIT);
    assign o_res       = '{column_out: r_cmd.column, new_first: r_new1,
                           new_second: r_new2, new_third: r_new3};

    `MSPTU_ASSERT_IMP(a_emit_busy, i_clk, i_rst_n, o_res_valid, busy)
    `MSPTU_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `MSPTU_ASSERT_NXT(a_one_strobe, i_clk, i_rst_n, o_res_valid, !o_res_valid)
    `MSPTU_ASSERT_IMP(a_fpu_free, i_clk, i_rst_n, fpu_req.go, !fpu_rsp.busy)

endmodule
`default_nettype wire

// File: dv/masked_sparse_triple_product_update_checker.sv
`default_nettype none
module masked_sparse_triple_product_update_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic            busy,
    input  msptu_pkg::t_cmd i_cmd,
    input  logic            o_res_valid,
    input  msptu_pkg::t_res o_res,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_data,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_checked
);
    import msptu_pkg::*;

    real        scale_val;
    real        acc_mem [DOF_COUNT];
    logic [1:0] mode;
    t_res       row_updates [$];

    function automatic real quotient(logic [63:0] n, logic [63:0] d);
        logic [63:0] nmag;
        logic [63:0] dmag;
        nmag = n & 64'h7FFF_FFFF_FFFF_FFFF;
        dmag = d & 64'h7FFF_FFFF_FFFF_FFFF;
        if (dmag == 0) begin
            if (nmag == 0 || nmag > 64'h7FF0_0000_0000_0000)
                return $bitstoreal(DBL_NAN_POS);
            return $bitstoreal(((n ^ d) & 64'h8000_0000_0000_0000) | 64'h7FF0_0000_0000_0000);
        end
        return $bitstoreal(n) / $bitstoreal(d);
    endfunction

    task automatic update_row(input t_cmd c);
        real  v;
        real  half;
        t_res r;
        case (c.kind)
            KIND_SCALE: scale_val = quotient(c.tilde_g_entry, c.mass_entry);
            KIND_ACC: acc_mem[c.column] = acc_mem[c.column] + scale_val * $bitstoreal(c.g_entry);
            KIND_APPLY: begin
                v = acc_mem[c.column];
                half = v / 2.0;
                r.column_out = c.column;
                if (mode == MODE_OFFDIAG) begin
                    r.new_first  = $realtobits($bitstoreal(c.first_entry) - half);
                    r.new_second = '0;
                    r.new_third  = '0;
                end else begin
                    r.new_first  = $realtobits($bitstoreal(c.first_entry)
                                               - (mode == 2'd1 ? v : half));
                    r.new_second = $realtobits($bitstoreal(c.second_entry)
                                               - (mode == 2'd2 ? v : half));
                    r.new_third  = $realtobits($bitstoreal(c.third_entry)
                                               - (mode == 2'd3 ? v : half));
                end
                acc_mem[c.column] = 0.0;
                row_updates.push_back(r);
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_res exp_r;
        if (!i_rst_n) begin
            scale_val = 0.0;
            for (int i = 0; i < DOF_COUNT; i++) acc_mem[i] = 0.0;
            mode = MODE_OFFDIAG;
            row_updates.delete();
            o_fail_count <= 0;
            o_checked <= 0;
        end else begin
            if (o_res_valid) begin
                if (row_updates.size() == 0) begin
                    $display("%0t: unexpected result, got %h", $time, o_res);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = row_updates.pop_front();
                    o_checked <= o_checked + 1;
                    if (o_res !== exp_r) begin
                        $display("%0t: mismatch col exp %h got %h", $time,
                                 exp_r.column_out, o_res.column_out);
                        $display("%0t:   first exp %h got %h", $time,
                                 exp_r.new_first, o_res.new_first);
                        $display("%0t:   second exp %h got %h", $time,
                                 exp_r.new_second, o_res.new_second);
                        $display("%0t:   third exp %h got %h", $time,
                                 exp_r.new_third, o_res.new_third);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (start && !busy) update_row(i_cmd);
            if (i_cfg_we) mode = i_cfg_data;
        end
        o_pending <= row_updates.size();
    end
endmodule
`default_nettype wire

// File: dv/masked_sparse_triple_product_update_tb.sv
`default_nettype none
module masked_sparse_triple_product_update_tb;
    import msptu_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_WAIT = 400;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_cmd       i_cmd = '0;
    logic       o_res_valid;
    t_res       o_res;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_data = '0;
    int         fail_count;
    int         pending;
    int         checked;
    int         sent = 0;
    int         idle_cycles = 0;
    bit         no_gaps = 0;

    always #1 i_clk = ~i_clk;

    masked_sparse_triple_product_update dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_cmd(i_cmd),
        .o_res_valid(o_res_valid), .o_res(o_res),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    masked_sparse_triple_product_update_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_cmd(i_cmd),
        .o_res_valid(o_res_valid), .o_res(o_res),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_res_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [63:0] rand_double();
        int pick;
        pick = $urandom_range(99);
        if (pick < 75)
            return {1'($urandom), 11'($urandom_range(1033, 1013)), $urandom, 20'($urandom)};
        if (pick < 85)
            return {1'($urandom), 63'd0};
        return {$urandom, $urandom};
    endfunction

    // drive one transfer; start stays high when the next one follows at once
    task automatic send(input t_cmd c);
        int  pick;
        int  gap;
        bit  ok;
        pick = $urandom_range(99);
        gap = no_gaps ? 0 : (pick < 70 ? 0 : (pick < 95 ? $urandom_range(3, 1)
                                                        : $urandom_range(200, 20)));
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do begin
            @(negedge i_clk);
            ok = !busy;
            @(posedge i_clk);
        end while (!ok);
        sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0 || o_res_valid) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_cmd make_cmd(logic [1:0] k, logic [11:0] col);
        t_cmd c;
        c.kind = k;
        c.column = col;
        c.tilde_g_entry = rand_double();
        c.mass_entry = rand_double();
        c.g_entry = rand_double();
        c.first_entry = rand_double();
        c.second_entry = rand_double();
        c.third_entry = rand_double();
        return c;
    endfunction

    task automatic random_rows(input int count);
        logic [11:0] cols [4];
        int          ncols;
        int          stop;
        stop = sent + count;
        while (sent < stop) begin
            if ($urandom_range(9) == 0) begin
                send(make_cmd(2'($urandom), 12'($urandom)));
            end else begin
                ncols = $urandom_range(4, 1);
                for (int i = 0; i < ncols; i++)
                    cols[i] = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(15));
                repeat ($urandom_range(3, 1)) begin
                    send(make_cmd(KIND_SCALE, 12'($urandom)));
                    for (int i = 0; i < ncols; i++)
                        if ($urandom_range(3) != 0) send(make_cmd(KIND_ACC, cols[i]));
                end
                for (int i = 0; i < ncols; i++) send(make_cmd(KIND_APPLY, cols[i]));
            end
            if ($urandom_range(15) == 0) no_gaps = !no_gaps;
        end
    endtask

    task automatic directed();
        t_cmd c;
        logic [63:0] nums [4];
        nums[0] = 64'h0;
        nums[1] = 64'h7FF8_0000_0000_0001;
        nums[2] = 64'h4000_0000_0000_0000;
        nums[3] = 64'hC008_0000_0000_0000;
        // zero divisor, both signs
        for (int i = 0; i < 4; i++) begin
            c = make_cmd(KIND_SCALE, 12'd0);
            c.tilde_g_entry = nums[i];
            c.mass_entry = (i % 2) ? 64'h8000_0000_0000_0000 : 64'h0;
            send(c);
            c = make_cmd(KIND_ACC, 12'd4095);
            c.g_entry = 64'h3FF0_0000_0000_0000;
            send(c);
            send(make_cmd(KIND_APPLY, 12'd4095));
        end
        c = make_cmd(KIND_SCALE, '1);
        c.tilde_g_entry = '1;
        c.mass_entry = '1;
        send(c);
        c = make_cmd(KIND_ACC, 12'd0);
        c.g_entry = '1;
        send(c);
        c = make_cmd(KIND_APPLY, 12'd0);
        c.first_entry = '1;
        c.second_entry = '1;
        c.third_entry = '1;
        send(c);
        send(make_cmd(2'd3, 12'd5));
        send(make_cmd(KIND_APPLY, 12'd7));
        c = make_cmd(KIND_APPLY, 12'd0);
        c.first_entry = '0;
        c.second_entry = '0;
        c.third_entry = '0;
        send(c);
    endtask

    initial begin
        logic [1:0] modes [6];
        modes = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd3, 2'd0};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < 6; p++) begin
            write_mode(modes[p]);
            directed();
            random_rows(140);
            drain();
            random_rows(140);
            drain();
        end
        $display("sent %0d items over all four block modes, %0d row updates checked",
                 sent, checked);
        if (fail_count == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire
